// File: rtl/ssh_pkg.sv
// ----------------------------------------------------------------------------
// Species slab histogram package
// Shared constants, codes and item types of the species slab histogram.
// ----------------------------------------------------------------------------
package ssh_pkg;

    localparam int NUM_BINS_DEF   = 64;
    localparam int COUNT_BITS_DEF = 32;

    localparam int HEIGHT_W  = 32;
    localparam int CHARGE_W  = 16;
    localparam int RBIN_W    = 6;
    localparam int OBIN_W    = 6;
    localparam int SPC_W     = 2;
    localparam int OCNT_W    = 32;
    localparam int WIDTH_W   = 32;
    localparam int BCOUNT_W  = 7;
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 32;

    // Dividend of the slab division: height minus one, height known positive
    localparam int DVD_W = HEIGHT_W - 1;
    localparam int DVS_W = WIDTH_W;

    localparam logic CMD_ADD  = 1'b0;
    localparam logic CMD_READ = 1'b1;

    localparam logic [SPC_W-1:0] SPC_LIGHT  = 2'd0;
    localparam logic [SPC_W-1:0] SPC_MIDDLE = 2'd1;
    localparam logic [SPC_W-1:0] SPC_HEAVY  = 2'd2;

    localparam logic [CFG_ADDR_W-1:0] REG_BIN_WIDTH   = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_BIN_COUNT   = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_LOW_CHARGE  = 2'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_HIGH_CHARGE = 2'd3;

    localparam logic [WIDTH_W-1:0]  BIN_WIDTH_RST   = 32'd65536;
    localparam logic [BCOUNT_W-1:0] BIN_COUNT_RST   = 7'd64;
    localparam logic [CHARGE_W-1:0] LOW_CHARGE_RST  = 16'd1792;
    localparam logic [CHARGE_W-1:0] HIGH_CHARGE_RST = 16'd2304;

    typedef struct packed {
        logic                       command;
        logic signed [HEIGHT_W-1:0] height;
        logic [CHARGE_W-1:0]        particle_charge;
        logic [RBIN_W-1:0]          read_bin;
    } req_item_t;

    typedef struct packed {
        logic [OBIN_W-1:0] bin_index;
        logic [SPC_W-1:0]  species;
        logic [OCNT_W-1:0] count_light;
        logic [OCNT_W-1:0] count_middle;
        logic [OCNT_W-1:0] count_heavy;
    } rsp_item_t;

    typedef struct packed {
        logic start;
    } div_ctl_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_sts_t;

endpackage

// File: rtl/ssh_stream_if.sv
// ----------------------------------------------------------------------------
// Species slab histogram stream channel
// Valid/ready channel carrying one request or result item.
// ----------------------------------------------------------------------------
interface ssh_stream_if #(parameter type item_t = logic);

    logic  valid;
    logic  ready;
    item_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);

endinterface

// File: rtl/species_slab_histogram_top.sv
// ----------------------------------------------------------------------------
// Species slab histogram
// Counts particles per height slab and charge species; reads back one slab.
// ----------------------------------------------------------------------------
// Usage:
//   req  : request channel (valid/ready). Command add bins a particle by
//          height and charge; command read returns the counters of read_bin.
//   rsp  : one result per request: slab, species and the slab's three
//          counters after the update.
//   cfg_we/cfg_addr/cfg_data : register writes; user writes only while idle, unchecked.
// Flow:
//   An add with a positive height and nonzero bin width runs the serial
//   divider, one quotient bit per cycle over 31 bits, then reads and writes
//   back its slab. Reads, and adds with a non-positive height or zero bin
//   width, skip the divider. One request is in flight at a time; req.ready
//   rises again as soon as the result is loaded into the output register.
// Reset:
//   Registers take their defaults, then the counter memory is zeroed one
//   slab per cycle, with req.ready low.
// Stall:
//   The result holds in the output register until taken; a following request
//   is worked up to its write-back and waits there.
// ----------------------------------------------------------------------------
module species_slab_histogram_top
#(
    parameter int NUM_BINS   = ssh_pkg::NUM_BINS_DEF,
    parameter int COUNT_BITS = ssh_pkg::COUNT_BITS_DEF
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    ssh_stream_if.sink                     req,
    ssh_stream_if.source                   rsp,
    input  logic                           cfg_we,
    input  logic [ssh_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  logic [ssh_pkg::CFG_DATA_W-1:0] cfg_data
);
    import ssh_pkg::*;

    localparam int BIN_W = (NUM_BINS > 1) ? $clog2(NUM_BINS) : 1;
    localparam int BC_W  = (BIN_W + 1 > BCOUNT_W) ? BIN_W + 1 : BCOUNT_W;
    localparam int RC_W  = (BIN_W > RBIN_W) ? BIN_W : RBIN_W;
    localparam int ROW_W = 3 * COUNT_BITS;

    typedef enum logic [4:0] {
        ST_CLEAR = 5'b00001,
        ST_IDLE  = 5'b00010,
        ST_DIV   = 5'b00100,
        ST_RD    = 5'b01000,
        ST_WB    = 5'b10000
    } state_t;

    state_t state_reg, state_next;

    logic [WIDTH_W-1:0]  bin_width_reg;
    logic [BCOUNT_W-1:0] bin_count_reg;
    logic [CHARGE_W-1:0] low_charge_reg;
    logic [CHARGE_W-1:0] high_charge_reg;

    logic             cmd_reg;
    logic [SPC_W-1:0] kind_reg, kind_next;
    logic [BIN_W-1:0] bin_reg, bin_next;
    logic [BIN_W-1:0] clr_reg;

    logic [ROW_W-1:0] mem [NUM_BINS];
    logic [ROW_W-1:0] rd_row_reg;
    logic [ROW_W-1:0] wb_row;
    logic             mem_we;
    logic [BIN_W-1:0] mem_waddr;
    logic [ROW_W-1:0] mem_wdata;

    logic             rsp_valid_reg;
    rsp_item_t        rsp_data_reg;
    logic             out_free;
    logic             req_take;

    logic [BC_W-1:0]  bc_ext, bc_act;
    logic [BIN_W-1:0] last_bin;
    logic [RC_W-1:0]  rb_ext;
    logic [BIN_W-1:0] read_slab;
    logic             height_pos;

    div_ctl_t         div_ctl;
    div_sts_t         div_sts;
    logic [DVD_W-1:0] div_dividend;
    logic [DVD_W-1:0] div_quotient;
    logic [BIN_W-1:0] div_slab;

    ssh_divider u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (div_ctl),
        .dividend (div_dividend),
        .divisor  (bin_width_reg),
        .sts      (div_sts),
        .quotient (div_quotient)
    );

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bin_width_reg   <= BIN_WIDTH_RST;
            bin_count_reg   <= BIN_COUNT_RST;
            low_charge_reg  <= LOW_CHARGE_RST;
            high_charge_reg <= HIGH_CHARGE_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                REG_BIN_WIDTH:   bin_width_reg   <= WIDTH_W'(cfg_data);
                REG_BIN_COUNT:   bin_count_reg   <= BCOUNT_W'(cfg_data);
                REG_LOW_CHARGE:  low_charge_reg  <= CHARGE_W'(cfg_data);
                REG_HIGH_CHARGE: high_charge_reg <= CHARGE_W'(cfg_data);
                default:         ;
            endcase
        end
    end

    // Active slab range and slab selection
    always_comb
    begin
        bc_ext = BC_W'(bin_count_reg);
        if (bc_ext == '0)
            bc_act = BC_W'(1);
        else if (bc_ext > BC_W'(NUM_BINS))
            bc_act = BC_W'(NUM_BINS);
        else
            bc_act = bc_ext;
        last_bin = BIN_W'(bc_act - BC_W'(1));

        rb_ext = RC_W'(req.data.read_bin);
        if (rb_ext > RC_W'(NUM_BINS - 1))
            read_slab = BIN_W'(NUM_BINS - 1);
        else
            read_slab = BIN_W'(rb_ext);

        if (div_quotient >= DVD_W'(last_bin))
            div_slab = last_bin;
        else
            div_slab = BIN_W'(div_quotient);

        height_pos   = !req.data.height[HEIGHT_W-1] && (req.data.height != '0);
        div_dividend = DVD_W'(req.data.height) - DVD_W'(1);

        if (req.data.particle_charge < low_charge_reg)
            kind_next = SPC_LIGHT;
        else if (req.data.particle_charge < high_charge_reg)
            kind_next = SPC_MIDDLE;
        else
            kind_next = SPC_HEAVY;
    end

    assign req.ready = (state_reg == ST_IDLE);
    assign req_take  = req.valid && req.ready;
    assign out_free  = !rsp_valid_reg || rsp.ready;

    // Updated row for write-back
    always_comb
    begin
        wb_row = rd_row_reg;
        if (cmd_reg == CMD_ADD)
        begin
            for (int k = 0; k < 3; k++)
            begin
                if (kind_reg == SPC_W'(k) &&
                    rd_row_reg[k*COUNT_BITS +: COUNT_BITS] != '1)
                begin
                    wb_row[k*COUNT_BITS +: COUNT_BITS] =
                        rd_row_reg[k*COUNT_BITS +: COUNT_BITS] + COUNT_BITS'(1);
                end
            end
        end
    end

    // Sequencer
    always_comb
    begin
        state_next    = state_reg;
        bin_next      = bin_reg;
        div_ctl.start = 1'b0;
        mem_we        = 1'b0;
        mem_waddr     = bin_reg;
        mem_wdata     = wb_row;
        case (state_reg)
            ST_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_waddr = clr_reg;
                mem_wdata = '0;
                if (clr_reg == BIN_W'(NUM_BINS - 1))
                    state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                if (req_take)
                begin
                    if (req.data.command == CMD_READ)
                    begin
                        bin_next   = read_slab;
                        state_next = ST_RD;
                    end
                    else if (!height_pos)
                    begin
                        bin_next   = '0;
                        state_next = ST_RD;
                    end
                    else if (bin_width_reg == '0)
                    begin
                        bin_next   = last_bin;
                        state_next = ST_RD;
                    end
                    else
                    begin
                        div_ctl.start = 1'b1;
                        state_next    = ST_DIV;
                    end
                end
            end
            ST_DIV:
            begin
                if (div_sts.done)
                begin
                    bin_next   = div_slab;
                    state_next = ST_RD;
                end
            end
            ST_RD:
            begin
                state_next = ST_WB;
            end
            ST_WB:
            begin
                if (out_free)
                begin
                    mem_we     = (cmd_reg == CMD_ADD);
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_reg       <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_CLEAR)
                clr_reg <= clr_reg + BIN_W'(1);
            if (state_reg == ST_WB && out_free)
                rsp_valid_reg <= 1'b1;
            else if (rsp.ready)
                rsp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        bin_reg <= bin_next;
        if (req_take)
        begin
            cmd_reg  <= req.data.command;
            kind_reg <= (req.data.command == CMD_READ) ? SPC_LIGHT : kind_next;
        end
        if (state_reg == ST_WB && out_free)
        begin
            rsp_data_reg.bin_index    <= OBIN_W'(bin_reg);
            rsp_data_reg.species      <= kind_reg;
            rsp_data_reg.count_light  <= OCNT_W'(wb_row[0*COUNT_BITS +: COUNT_BITS]);
            rsp_data_reg.count_middle <= OCNT_W'(wb_row[1*COUNT_BITS +: COUNT_BITS]);
            rsp_data_reg.count_heavy  <= OCNT_W'(wb_row[2*COUNT_BITS +: COUNT_BITS]);
        end
    end

    // Counter memory: one row of three counters per slab
    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_waddr] <= mem_wdata;
        rd_row_reg <= mem[bin_reg];
    end

    assign rsp.valid = rsp_valid_reg;
    assign rsp.data  = rsp_data_reg;

endmodule

// File: rtl/ssh_divider.sv
// ----------------------------------------------------------------------------
// Species slab histogram divider
// Restoring divider, one quotient bit per cycle, used by adds with a positive height and nonzero bin width.
// ----------------------------------------------------------------------------
module ssh_divider
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  ssh_pkg::div_ctl_t         ctl,
    input  logic [ssh_pkg::DVD_W-1:0] dividend,
    input  logic [ssh_pkg::DVS_W-1:0] divisor,
    output ssh_pkg::div_sts_t         sts,
    output logic [ssh_pkg::DVD_W-1:0] quotient
);
    import ssh_pkg::*;

    localparam int CNT_W = $clog2(DVD_W);

    logic [DVS_W-1:0] rem_reg, rem_next;
    logic [DVS_W-1:0] dvs_reg;
    logic [DVD_W-1:0] dvd_reg;
    logic [DVD_W-1:0] quo_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;
    logic [DVS_W:0]   trial;
    logic             fits;

    always_comb
    begin
        trial    = {rem_reg, dvd_reg[DVD_W-1]};
        fits     = trial >= {1'b0, dvs_reg};
        rem_next = fits ? DVS_W'(trial - {1'b0, dvs_reg}) : DVS_W'(trial);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (ctl.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                if (cnt_reg == CNT_W'(DVD_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                cnt_reg <= cnt_reg + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.start)
        begin
            rem_reg <= '0;
            dvs_reg <= divisor;
            dvd_reg <= dividend;
            quo_reg <= '0;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            dvd_reg <= {dvd_reg[DVD_W-2:0], 1'b0};
            quo_reg <= {quo_reg[DVD_W-2:0], fits};
        end
    end

    assign sts.busy = busy_reg;
    assign sts.done = done_reg;
    assign quotient = quo_reg;

endmodule

// File: rtl/ssh_checker.sv
// ----------------------------------------------------------------------------
// Species slab histogram checker
// Port-level assertions on the request and result channels.
// ----------------------------------------------------------------------------
module ssh_checker
(
    input logic                     clk,
    input logic                     rst_n,
    input logic                     req_valid,
    input logic                     req_ready,
    input logic                     rsp_valid,
    input logic                     rsp_ready,
    input logic [ssh_pkg::SPC_W-1:0] rsp_species,
    input ssh_pkg::rsp_item_t       rsp_data
);
    import ssh_pkg::*;

    // Hold a stalled result
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
        else $error("result changed while stalled");

    // Drop ready after a request is taken
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("request taken while busy");

    // Species code is always a valid class
    a_species_code: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (rsp_species == SPC_LIGHT || rsp_species == SPC_MIDDLE ||
                       rsp_species == SPC_HEAVY))
        else $error("bad species code");

    // No result appears in the cycle right after a request is taken
    a_no_early_rsp: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready && !rsp_valid |=> !rsp_valid)
        else $error("result ahead of work");

endmodule

bind species_slab_histogram_top ssh_checker u_ssh_checker
(
    .clk         (clk),
    .rst_n       (rst_n),
    .req_valid   (req.valid),
    .req_ready   (req.ready),
    .rsp_valid   (rsp.valid),
    .rsp_ready   (rsp.ready),
    .rsp_species (rsp.data.species),
    .rsp_data    (rsp.data)
);

// File: bench/tb_top.sv
// ----------------------------------------------------------------------------
// Species slab histogram testbench
// Drives add and read requests through the request channel under random
// gaps on both sides. A running slab tally predicts every result, and each
// result is checked field by field against the oldest prediction. The run
// steps through several register settings, including zero bin width, a
// clamped bin count, a single slab and crossed charge limits.
// ----------------------------------------------------------------------------
module tb_top;

    import ssh_pkg::*;

    localparam int BINS  = NUM_BINS_DEF;
    localparam int CNT_W = COUNT_BITS_DEF;

    class slab_tally;
        logic [WIDTH_W-1:0]  width_q;
        logic [BCOUNT_W-1:0] count_q;
        logic [CHARGE_W-1:0] low_q;
        logic [CHARGE_W-1:0] high_q;
        logic [CNT_W-1:0]    tally [3][BINS];
        rsp_item_t           owed_tallies [$];
        int                  errors;

        function new();
            width_q = BIN_WIDTH_RST;
            count_q = BIN_COUNT_RST;
            low_q   = LOW_CHARGE_RST;
            high_q  = HIGH_CHARGE_RST;
            errors  = 0;
            foreach (tally[k, b])
            begin
                tally[k][b] = '0;
            end
        endfunction

        function void set_reg(logic [CFG_ADDR_W-1:0] idx, logic [CFG_DATA_W-1:0] v);
            case (idx)
                REG_BIN_WIDTH:   width_q = v[WIDTH_W-1:0];
                REG_BIN_COUNT:   count_q = v[BCOUNT_W-1:0];
                REG_LOW_CHARGE:  low_q   = v[CHARGE_W-1:0];
                REG_HIGH_CHARGE: high_q  = v[CHARGE_W-1:0];
                default: ;
            endcase
        endfunction

        function int active_bins();
            if (count_q == '0)
                return 1;
            if (int'(count_q) > BINS)
                return BINS;
            return int'(count_q);
        endfunction

        function int slab_of_height(logic signed [HEIGHT_W-1:0] z);
            longint zl;
            int     bc;
            int     s;
            zl = longint'(z);
            bc = active_bins();
            s  = 0;
            for (int n = 1; n <= bc; n++)
            begin
                if (zl > longint'(n) * longint'({32'd0, width_q}))
                    s = n;
            end
            if (s > bc - 1)
                s = bc - 1;
            return s;
        endfunction

        function logic [SPC_W-1:0] species_of(logic [CHARGE_W-1:0] q);
            if (q < low_q)
                return SPC_LIGHT;
            if (q < high_q)
                return SPC_MIDDLE;
            return SPC_HEAVY;
        endfunction

        function void note_request(req_item_t r);
            rsp_item_t         e;
            int                s;
            logic [SPC_W-1:0]  k;
            if (r.command == CMD_ADD)
            begin
                s = slab_of_height(r.height);
                k = species_of(r.particle_charge);
                if (tally[k][s] != '1)
                    tally[k][s] = tally[k][s] + CNT_W'(1);
            end
            else
            begin
                s = (int'(r.read_bin) > BINS - 1) ? BINS - 1 : int'(r.read_bin);
                k = SPC_LIGHT;
            end
            e.bin_index    = s[OBIN_W-1:0];
            e.species      = k;
            e.count_light  = tally[SPC_LIGHT][s][OCNT_W-1:0];
            e.count_middle = tally[SPC_MIDDLE][s][OCNT_W-1:0];
            e.count_heavy  = tally[SPC_HEAVY][s][OCNT_W-1:0];
            owed_tallies.push_back(e);
        endfunction

        function void compare_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
            if (act_v !== exp_v)
            begin
                $error("%s: expected %0d, got %0d", name, exp_v, act_v);
                errors++;
            end
        endfunction

        function void check_result(rsp_item_t got);
            rsp_item_t e;
            if (owed_tallies.size() == 0)
            begin
                $error("bin_index: expected no result, got %0d", got.bin_index);
                errors++;
                return;
            end
            e = owed_tallies.pop_front();
            compare_field("bin_index", 32'(e.bin_index), 32'(got.bin_index));
            compare_field("species", 32'(e.species), 32'(got.species));
            compare_field("count_light", e.count_light, got.count_light);
            compare_field("count_middle", e.count_middle, got.count_middle);
            compare_field("count_heavy", e.count_heavy, got.count_heavy);
        endfunction

        function int owed();
            return owed_tallies.size();
        endfunction
    endclass

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_ADDR_W-1:0] cfg_addr;
    logic [CFG_DATA_W-1:0] cfg_data;
    bit                    calm;

    ssh_stream_if #(.item_t(req_item_t)) req_if ();
    ssh_stream_if #(.item_t(rsp_item_t)) rsp_if ();

    slab_tally sb = new();

    species_slab_histogram_top dut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (req_if),
        .rsp      (rsp_if),
        .cfg_we   (cfg_we),
        .cfg_addr (cfg_addr),
        .cfg_data (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("status: fail");
        $finish;
    end

    function automatic int pick_gap();
        int roll;
        if (calm)
            return 0;
        roll = $urandom_range(0, 99);
        if (roll < 60)
            return 0;
        if (roll < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic req_item_t add_req(logic [31:0] h, logic [15:0] q);
        req_item_t r;
        r                 = '0;
        r.command         = CMD_ADD;
        r.height          = h;
        r.particle_charge = q;
        return r;
    endfunction

    function automatic req_item_t read_req(logic [RBIN_W-1:0] b);
        req_item_t r;
        r          = '0;
        r.command  = CMD_READ;
        r.read_bin = b;
        return r;
    endfunction

    function automatic req_item_t random_request();
        req_item_t r;
        longint    bw;
        longint    k;
        longint    h;
        r.command         = ($urandom_range(0, 99) < 30) ? CMD_READ : CMD_ADD;
        r.read_bin        = RBIN_W'($urandom_range(0, BINS - 1));
        r.particle_charge = CHARGE_W'($urandom);
        r.height          = $urandom;
        bw = longint'(sb.width_q);
        k  = longint'($urandom_range(0, sb.active_bins() + 1));
        case ($urandom_range(0, 3))
            0: ;
            1, 2:
            begin
                h = k * bw + ((bw == 0) ? longint'(0) : longint'($urandom) % bw);
                r.height = h[31:0];
            end
            default:
            begin
                h = k * bw + longint'($urandom_range(0, 2)) - longint'(1);
                r.height = h[31:0];
            end
        endcase
        case ($urandom_range(0, 3))
            0: r.particle_charge = CHARGE_W'(sb.low_q + int'($urandom_range(0, 2)) - 1);
            1: r.particle_charge = CHARGE_W'(sb.high_q + int'($urandom_range(0, 2)) - 1);
            default: ;
        endcase
        return r;
    endfunction

    task automatic send_request(req_item_t r);
        int gap;
        gap = pick_gap();
        @(negedge clk);
        if (gap > 0)
        begin
            req_if.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        req_if.valid <= 1'b1;
        req_if.data  <= r;
        do
            @(posedge clk);
        while (req_if.ready !== 1'b1);
        sb.note_request(r);
    endtask

    task automatic wait_drained();
        @(negedge clk) req_if.valid <= 1'b0;
        while (sb.owed() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_ADDR_W-1:0] idx, logic [CFG_DATA_W-1:0] v);
        @(negedge clk);
        cfg_we   <= 1'b1;
        cfg_addr <= idx;
        cfg_data <= v;
        sb.set_reg(idx, v);
        @(negedge clk);
        cfg_we   <= 1'b0;
    endtask

    task automatic run_phase(int n);
        repeat (n) send_request(random_request());
        wait_drained();
    endtask

    task automatic directed_requests();
        send_request(add_req(32'd0, 16'd0));
        send_request(add_req(32'hFFFF_FFFF, 16'hFFFF));
        send_request(add_req(32'h8000_0000, 16'd1791));
        send_request(add_req(32'h7FFF_FFFF, 16'd1792));
        send_request(add_req(32'd65536, 16'd2303));
        send_request(add_req(32'd65537, 16'd2304));
        send_request(add_req(32'd4194304, 16'd2000));
        send_request(add_req(32'd4194305, 16'h8000));
        send_request(add_req(32'd131073, 16'h5555));
        send_request(add_req(32'h5555_5555, 16'hAAAA));
        send_request(add_req(32'hAAAA_AAAA, 16'd1));
        send_request(add_req(32'd1, 16'd1000));
        send_request(read_req(6'd0));
        send_request(read_req(6'd1));
        send_request(read_req(6'd2));
        send_request(read_req(6'd62));
        send_request(read_req(6'd63));
        send_request(read_req(6'h2A));
        send_request(read_req(6'h15));
        wait_drained();
    endtask

    initial
    begin
        rsp_if.ready = 1'b0;
        @(negedge clk);
        forever
        begin : sink_loop
            int stall;
            stall = pick_gap();
            if (stall > 0)
            begin
                rsp_if.ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            rsp_if.ready <= 1'b1;
            @(negedge clk);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && rsp_if.valid && rsp_if.ready)
            sb.check_result(rsp_if.data);
    end

    initial
    begin
        rst_n        = 1'b0;
        req_if.valid = 1'b0;
        req_if.data  = '0;
        cfg_we       = 1'b0;
        cfg_addr     = '0;
        cfg_data     = '0;
        calm         = 1'b0;
        repeat (8) @(posedge clk);
        @(negedge clk) rst_n <= 1'b1;
        // hold until the counter clear has finished
        do
            @(posedge clk);
        while (req_if.ready !== 1'b1);

        directed_requests();

        write_reg(REG_BIN_WIDTH, 32'd0);
        write_reg(REG_BIN_COUNT, 32'd5);
        run_phase(55);

        write_reg(REG_BIN_WIDTH, 32'hFFFF_FFFF);
        write_reg(REG_BIN_COUNT, 32'd127);
        write_reg(REG_LOW_CHARGE, 32'd0);
        write_reg(REG_HIGH_CHARGE, 32'hFFFF);
        run_phase(30);
        run_phase(25);

        write_reg(REG_BIN_WIDTH, 32'd4096);
        write_reg(REG_BIN_COUNT, 32'd0);
        write_reg(REG_LOW_CHARGE, 32'd40000);
        write_reg(REG_HIGH_CHARGE, 32'd1000);
        run_phase(55);

        write_reg(REG_BIN_WIDTH, 32'd1);
        write_reg(REG_BIN_COUNT, 32'd1);
        write_reg(REG_LOW_CHARGE, 32'hFFFF);
        write_reg(REG_HIGH_CHARGE, 32'hFFFF);
        run_phase(45);

        calm = 1'b1;
        write_reg(REG_BIN_WIDTH, 32'd65536);
        write_reg(REG_BIN_COUNT, 32'd64);
        write_reg(REG_LOW_CHARGE, 32'd1792);
        write_reg(REG_HIGH_CHARGE, 32'd2304);
        run_phase(60);
        calm = 1'b0;

        write_reg(REG_BIN_WIDTH, $urandom_range(1, 200000));
        write_reg(REG_BIN_COUNT, 32'd3);
        write_reg(REG_LOW_CHARGE, $urandom_range(0, 65535));
        write_reg(REG_HIGH_CHARGE, $urandom_range(0, 65535));
        run_phase(55);

        write_reg(REG_BIN_WIDTH, $urandom_range(1, 32'h0010_0000));
        write_reg(REG_BIN_COUNT, $urandom_range(1, 64));
        write_reg(REG_LOW_CHARGE, $urandom_range(0, 4000));
        write_reg(REG_HIGH_CHARGE, $urandom_range(0, 4000));
        run_phase(60);

        if (sb.errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

// File: files.f
rtl/ssh_pkg.sv
rtl/ssh_stream_if.sv
rtl/ssh_divider.sv
rtl/species_slab_histogram_top.sv
rtl/ssh_checker.sv
bench/tb_top.sv
